>>> sv/lsm_pkg.sv
package lsm_pkg;

	// Field widths of the channels and the configuration port
	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 32;
	localparam int ADDR_W = 4;

	localparam int DEF_SEQ_BITS = 32;
	localparam int DEF_TIME_BITS = 32;

	// Register values after reset
	localparam logic [BYTE_W-1:0] RST_VERSION = 8'd1;
	localparam logic [BYTE_W-1:0] RST_LENGTH = 8'd32;
	localparam logic [WORD_W-1:0] RST_TIMEOUT = 32'd1000;
	localparam logic [WORD_W-1:0] RST_INTERVAL = 32'd1000;

	typedef enum logic [KIND_W-1:0] {
		KIND_RX,
		KIND_SEND,
		KIND_TICK,
		KIND_BEACON
	} kind_t;

	typedef enum logic [ADDR_W-3:0] {
		REG_VERSION,
		REG_LENGTH,
		REG_TIMEOUT,
		REG_INTERVAL
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] expected_version;
		logic [BYTE_W-1:0] expected_length;
		logic [WORD_W-1:0] link_timeout;
		logic [WORD_W-1:0] beacon_interval;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] frame_length;
		logic [BYTE_W-1:0] frame_version;
		logic [WORD_W-1:0] frame_sequence;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic              relay;
		logic [WORD_W-1:0] relay_sequence;
		logic              beacon_sent;
		logic [WORD_W-1:0] beacon_sequence;
		logic [WORD_W-1:0] beacon_time;
		logic              link_active;
		logic [WORD_W-1:0] missed_total;
		logic [WORD_W-1:0] drop_total;
		logic [WORD_W-1:0] good_total;
	} result_t;

endpackage

>>> sv/lsm_if.sv
interface lsm_item_if;
	logic                        valid;
	logic                        ready;
	logic [lsm_pkg::KIND_W-1:0]  kind;
	logic [lsm_pkg::BYTE_W-1:0]  frame_length;
	logic [lsm_pkg::BYTE_W-1:0]  frame_version;
	logic [lsm_pkg::WORD_W-1:0]  frame_sequence;

	modport source (
		output valid, kind, frame_length, frame_version, frame_sequence,
		input  ready
	);
	modport sink (
		input  valid, kind, frame_length, frame_version, frame_sequence,
		output ready
	);
endinterface

interface lsm_result_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic                        relay;
	logic [lsm_pkg::WORD_W-1:0]  relay_sequence;
	logic                        beacon_sent;
	logic [lsm_pkg::WORD_W-1:0]  beacon_sequence;
	logic [lsm_pkg::WORD_W-1:0]  beacon_time;
	logic                        link_active;
	logic [lsm_pkg::WORD_W-1:0]  missed_total;
	logic [lsm_pkg::WORD_W-1:0]  drop_total;
	logic [lsm_pkg::WORD_W-1:0]  good_total;

	modport source (
		output valid, accepted, relay, relay_sequence, beacon_sent, beacon_sequence,
		       beacon_time, link_active, missed_total, drop_total, good_total,
		input  ready
	);
	modport sink (
		input  valid, accepted, relay, relay_sequence, beacon_sent, beacon_sequence,
		       beacon_time, link_active, missed_total, drop_total, good_total,
		output ready
	);
endinterface

>>> sv/link_sequence_monitor.sv
// Link sequence monitor.
//
// Events arrive on the item channel (valid/ready): a received frame, a local
// send, a millisecond tick or a beacon request. Each event yields exactly one
// request on the result channel, carrying the acceptance and relay decision,
// any granted beacon, the link activity flag and the running counters.
//
// An accepted event is registered, then evaluated against the monitor state
// once the output register is free or being emptied; its result is written there.
// While the receiver keeps up, one event per cycle is sustained; the single
// state update per cycle in the evaluation stage sets that rate.
// When the receiver stalls, the result waits in the output register and one
// further event may wait in the input register; after that ready drops.
//
// Reset clears all counters, times and sequences and loads the registers
// with their defaults (version 1, length 32, timeout and interval 1000).
// The APB registers are meant to be written only while no event is in flight.
module link_sequence_monitor #(
	parameter int SEQ_BITS = lsm_pkg::DEF_SEQ_BITS,
	parameter int TIME_BITS = lsm_pkg::DEF_TIME_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lsm_item_if.sink                    item,
	lsm_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsm_pkg::ADDR_W-1:0]  paddr,
	input  logic [lsm_pkg::WORD_W-1:0]  pwdata,
	output logic [lsm_pkg::WORD_W-1:0]  prdata,
	output logic                        pready
);

	lsm_pkg::cfg_t    cfg;
	lsm_pkg::item_t   item_s1;
	logic             valid_s1;
	lsm_pkg::result_t res_d;
	lsm_pkg::result_t res_q;
	logic             res_valid_q;
	logic             advance;
	logic             take;

	assign pready = 1'b1;

	lsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The evaluation stage moves on whenever the output register is free or being emptied.
	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind <= item.kind;
			item_s1.frame_length <= item.frame_length;
			item_s1.frame_version <= item.frame_version;
			item_s1.frame_sequence <= item.frame_sequence;
		end
	end

	lsm_core #(
		.SEQ_BITS  (SEQ_BITS),
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.accepted = res_q.accepted;
	assign result.relay = res_q.relay;
	assign result.relay_sequence = res_q.relay_sequence;
	assign result.beacon_sent = res_q.beacon_sent;
	assign result.beacon_sequence = res_q.beacon_sequence;
	assign result.beacon_time = res_q.beacon_time;
	assign result.link_active = res_q.link_active;
	assign result.missed_total = res_q.missed_total;
	assign result.drop_total = res_q.drop_total;
	assign result.good_total = res_q.good_total;

	// A relay decision is only ever made for a frame that passed the checks.
	a_relay_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (!result.relay || result.accepted))
		else $error("relay flagged on a frame that was not accepted");

	// A beacon grant and a frame acceptance come from different event kinds.
	a_beacon_not_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.beacon_sent |-> !result.accepted)
		else $error("beacon granted together with an accepted frame");

	// With both stages full and the receiver stalled, no further event is taken.
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !result.ready |-> !item.ready)
		else $error("event taken while both stages are full");

	// An evaluated event always leaves a request in the output register.
	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("evaluated event produced no result request");

endmodule

>>> sv/lsm_regs.sv
module lsm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsm_pkg::ADDR_W-1:0]  paddr,
	input  logic [lsm_pkg::WORD_W-1:0]  pwdata,
	output logic [lsm_pkg::WORD_W-1:0]  prdata,
	output lsm_pkg::cfg_t               cfg
);

	lsm_pkg::cfg_t     cfg_q;
	lsm_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx = lsm_pkg::reg_idx_t'(paddr[lsm_pkg::ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= lsm_pkg::RST_VERSION;
			cfg_q.expected_length <= lsm_pkg::RST_LENGTH;
			cfg_q.link_timeout <= lsm_pkg::RST_TIMEOUT;
			cfg_q.beacon_interval <= lsm_pkg::RST_INTERVAL;
		end else if (wr_en) begin
			case (idx)
				lsm_pkg::REG_VERSION: begin
					cfg_q.expected_version <= pwdata[lsm_pkg::BYTE_W-1:0];
				end
				lsm_pkg::REG_LENGTH: begin
					cfg_q.expected_length <= pwdata[lsm_pkg::BYTE_W-1:0];
				end
				lsm_pkg::REG_TIMEOUT: begin
					cfg_q.link_timeout <= pwdata;
				end
				default: begin
					cfg_q.beacon_interval <= pwdata;
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			lsm_pkg::REG_VERSION: prdata = lsm_pkg::WORD_W'(cfg_q.expected_version);
			lsm_pkg::REG_LENGTH:  prdata = lsm_pkg::WORD_W'(cfg_q.expected_length);
			lsm_pkg::REG_TIMEOUT: prdata = cfg_q.link_timeout;
			default:              prdata = cfg_q.beacon_interval;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> sv/lsm_core.sv
module lsm_core #(
	parameter int SEQ_BITS = lsm_pkg::DEF_SEQ_BITS,
	parameter int TIME_BITS = lsm_pkg::DEF_TIME_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  lsm_pkg::item_t   item,
	input  lsm_pkg::cfg_t    cfg,
	output lsm_pkg::result_t res
);

	localparam int CNT_W = lsm_pkg::WORD_W;
	// Ages and limits are compared at the wider of the time width and the register width.
	localparam int CMP_BITS = (TIME_BITS > CNT_W) ? TIME_BITS : CNT_W;

	logic [TIME_BITS-1:0] time_now_q, time_now_d;
	logic [TIME_BITS-1:0] last_valid_time_q, last_valid_time_d;
	logic [TIME_BITS-1:0] last_beacon_time_q, last_beacon_time_d;
	logic                 seen_any_q, seen_any_d;
	logic [SEQ_BITS-1:0]  last_rx_seq_q, last_rx_seq_d;
	logic [SEQ_BITS-1:0]  last_sent_seq_q, last_sent_seq_d;
	logic [SEQ_BITS-1:0]  last_relayed_seq_q, last_relayed_seq_d;
	logic [SEQ_BITS-1:0]  beacon_counter_q, beacon_counter_d;
	logic [CNT_W-1:0]     missed_q, missed_d;
	logic [CNT_W-1:0]     drop_q, drop_d;
	logic [CNT_W-1:0]     good_q, good_d;

	logic [SEQ_BITS-1:0]  seq;
	logic [SEQ_BITS-1:0]  gap;
	logic [TIME_BITS-1:0] beacon_age;
	logic [TIME_BITS-1:0] link_age;
	logic                 beacon_ok;
	lsm_pkg::kind_t       kind;

	assign kind = lsm_pkg::kind_t'(item.kind);
	assign seq = SEQ_BITS'(item.frame_sequence);
	assign gap = seq - last_rx_seq_q;
	assign beacon_age = time_now_q - last_beacon_time_q;
	assign beacon_ok = CMP_BITS'(beacon_age) >= CMP_BITS'(cfg.beacon_interval);

	always_comb begin
		time_now_d = time_now_q;
		last_valid_time_d = last_valid_time_q;
		last_beacon_time_d = last_beacon_time_q;
		seen_any_d = seen_any_q;
		last_rx_seq_d = last_rx_seq_q;
		last_sent_seq_d = last_sent_seq_q;
		last_relayed_seq_d = last_relayed_seq_q;
		beacon_counter_d = beacon_counter_q;
		missed_d = missed_q;
		drop_d = drop_q;
		good_d = good_q;
		res = '0;

		case (kind)
			lsm_pkg::KIND_RX: begin
				if (item.frame_length != cfg.expected_length ||
				    item.frame_version != cfg.expected_version) begin
					drop_d = drop_q + CNT_W'(1);
				end else begin
					res.accepted = 1'b1;
					// A gap of one is the next frame in order; nothing counts before the first frame.
					if (seen_any_q && gap > SEQ_BITS'(1)) begin
						missed_d = missed_q + CNT_W'(gap - SEQ_BITS'(1));
					end
					last_rx_seq_d = seq;
					seen_any_d = 1'b1;
					last_valid_time_d = time_now_q;
					good_d = good_q + CNT_W'(1);
					if (seq != '0 && seq != last_sent_seq_q && seq != last_relayed_seq_q) begin
						res.relay = 1'b1;
						res.relay_sequence = CNT_W'(seq);
						last_relayed_seq_d = seq;
						last_sent_seq_d = seq;
					end
				end
			end
			lsm_pkg::KIND_SEND: begin
				last_sent_seq_d = seq;
			end
			lsm_pkg::KIND_TICK: begin
				time_now_d = time_now_q + TIME_BITS'(1);
			end
			default: begin
				if (beacon_ok) begin
					beacon_counter_d = beacon_counter_q + SEQ_BITS'(1);
					last_beacon_time_d = time_now_q;
					res.beacon_sent = 1'b1;
					res.beacon_sequence = CNT_W'(beacon_counter_d);
					res.beacon_time = CNT_W'(time_now_q);
				end
			end
		endcase

		res.missed_total = missed_d;
		res.drop_total = drop_d;
		res.good_total = good_d;

		// Link activity is judged on the state as it stands after this event.
		link_age = time_now_d - last_valid_time_d;
		res.link_active = seen_any_d &&
			(CMP_BITS'(link_age) <= CMP_BITS'(cfg.link_timeout));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q <= '0;
			last_valid_time_q <= '0;
			last_beacon_time_q <= '0;
			seen_any_q <= 1'b0;
			last_rx_seq_q <= '0;
			last_sent_seq_q <= '0;
			last_relayed_seq_q <= '0;
			beacon_counter_q <= '0;
			missed_q <= '0;
			drop_q <= '0;
			good_q <= '0;
		end else if (fire) begin
			time_now_q <= time_now_d;
			last_valid_time_q <= last_valid_time_d;
			last_beacon_time_q <= last_beacon_time_d;
			seen_any_q <= seen_any_d;
			last_rx_seq_q <= last_rx_seq_d;
			last_sent_seq_q <= last_sent_seq_d;
			last_relayed_seq_q <= last_relayed_seq_d;
			beacon_counter_q <= beacon_counter_d;
			missed_q <= missed_d;
			drop_q <= drop_d;
			good_q <= good_d;
		end
	end

endmodule
